@@ design/mnt_pkg.sv @@
// ============================================================================
// mnt_pkg: shared types and constants of the mesh neighbor table
// Holds command codes, table sizes, register indexes and sequencer states.
// ============================================================================
package mnt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W       = 8 + CNT_W;
    localparam int DCNT_W      = $clog2(SUM_W + 1);
    localparam int ENT_W       = 80;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_PRUNE = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_EDGE_THR  = 2'd0;
    localparam logic [1:0] REG_EDGE_LIM  = 2'd1;
    localparam logic [1:0] REG_CAND_LIM  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_PRN_RD,
        ST_PRN_CHK,
        ST_STAT_RD,
        ST_STAT_ACC,
        ST_DIV,
        ST_FLAGS,
        ST_OUT
    } t_state;

endpackage

@@ design/mesh_neighbor_table.sv @@
// ============================================================================
// mesh_neighbor_table: neighbor table of a mesh node with aging
// Add/update, tick, prune and query commands; every item yields one result
// with entry count, one-hop count, average signal and edge/candidate flags.
// ============================================================================
// Channel   Dir  Handshake            Payload
// s_axis    in   s_axis_tvalid/tready tdata: cmd, id, signal, hops, max_age
// m_axis    out  m_axis_tvalid/tready tdata: accepted .. candidate_flag
// cfg       in   i_cfg_we             i_cfg_idx, i_cfg_data
//
// Steps: an add runs a search walk, a prune a prune walk; every item then
// runs a statistics walk, the restoring divider over SUM_W = 16 dividend
// bits and the flag and output states. The entry memory has a registered
// read, so each walk visits an entry in a read state then a check state.
// Reset clears the state, configuration, entry count and tick counter only;
// the entry store needs no clearing since only entries below the count are
// read. The input is held off until the result item is taken.
// ============================================================================
module mesh_neighbor_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: cmd[1:0], node_id[33:2], signal_strength[41:34],
    //        hops[49:42], max_age[81:50], zero fill to 88
    input  logic [87:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: accepted[0], removed_count[8:1], entry_total[16:9],
    //        direct_total[24:17], average_signal[32:25], edge_flag[33],
    //        candidate_flag[34], zero fill to 40
    output logic [39:0]          m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);
    import mnt_pkg::*;

    // entry memory: id, signal, hops, seen
    logic [ENT_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0] r_rd_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [ENT_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    t_state r_state, n_state;
    logic signed [7:0] r_thr;
    logic [7:0]        r_edge_lim, r_cand_lim;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [31:0]       r_tick, n_tick;
    logic [31:0]       r_id, n_id, r_max_age, n_max_age;
    logic [7:0]        r_sig, n_sig, r_hops, n_hops;
    logic [CNT_W-1:0]  r_rd, n_rd, r_wr, n_wr, r_direct, n_direct;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic              r_acc, n_acc;
    logic [CNT_W-1:0]  r_removed, n_removed;
    // restoring divider of |sum| by count
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic signed [7:0] r_avg, n_avg;
    logic              r_edge, n_edge, r_cand, n_cand;

    logic [SUM_W-1:0]  sum_mag;
    logic [31:0]       age;
    logic [SUM_W-1:0]  quo_s;

    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign age     = r_tick - r_rd_data[79:48];
    assign quo_s   = r_sum[SUM_W-1] ? SUM_W'(-r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_thr      <= -8'sd80;
            r_edge_lim <= 8'd3;
            r_cand_lim <= 8'd5;
            r_count    <= '0;
            r_tick     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_tick  <= n_tick;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_EDGE_THR: r_thr      <= signed'(i_cfg_data);
                    REG_EDGE_LIM: r_edge_lim <= i_cfg_data;
                    REG_CAND_LIM: r_cand_lim <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;    r_max_age <= n_max_age;
        r_sig <= n_sig;  r_hops <= n_hops;
        r_rd <= n_rd;    r_wr <= n_wr;  r_direct <= n_direct;
        r_sum <= n_sum;  r_acc <= n_acc; r_removed <= n_removed;
        r_quo <= n_quo;  r_rem <= n_rem; r_dcnt <= n_dcnt;
        r_avg <= n_avg;  r_edge <= n_edge; r_cand <= n_cand;
    end

    always_comb begin
        n_state = r_state;  n_count = r_count;  n_tick = r_tick;
        n_id = r_id; n_max_age = r_max_age;
        n_sig = r_sig; n_hops = r_hops;
        n_rd = r_rd; n_wr = r_wr; n_direct = r_direct; n_sum = r_sum;
        n_acc = r_acc; n_removed = r_removed;
        n_quo = r_quo; n_rem = r_rem; n_dcnt = r_dcnt;
        n_avg = r_avg; n_edge = r_edge; n_cand = r_cand;
        mem_we = 1'b0;
        mem_waddr = r_wr[IDX_W-1:0];
        mem_wdata = r_rd_data;
        mem_raddr = r_rd[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_id      = s_axis_tdata[33:2];
                    n_sig     = s_axis_tdata[41:34];
                    n_hops    = s_axis_tdata[49:42];
                    n_max_age = s_axis_tdata[81:50];
                    n_acc = 1'b0;  n_removed = '0;
                    n_rd = '0;     n_wr = '0;
                    case (t_cmd'(s_axis_tdata[1:0]))
                        CMD_ADD:   n_state = ST_SRCH_RD;
                        CMD_PRUNE: n_state = ST_PRN_RD;
                        CMD_TICK: begin
                            n_tick  = r_tick + 32'd1;
                            n_state = ST_STAT_RD;
                        end
                        default:   n_state = ST_STAT_RD;
                    endcase
                    n_direct = '0;  n_sum = '0;
                end
            end
            ST_SRCH_RD: begin
                // read issued this cycle at r_rd
                if (r_rd == r_count) begin
                    if (r_count != CNT_W'(TABLE_DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[IDX_W-1:0];
                        mem_wdata = {r_tick, r_hops, r_sig, r_id};
                        n_count   = r_count + 1'b1;
                        n_acc     = 1'b1;
                    end
                    n_rd = '0;
                    n_state = ST_STAT_RD;
                end else begin
                    n_state = ST_SRCH_CHK;
                end
            end
            ST_SRCH_CHK: begin
                if (r_rd_data[31:0] == r_id) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd[IDX_W-1:0];
                    mem_wdata = {r_tick, r_hops, r_sig, r_id};
                    n_acc   = 1'b1;
                    n_rd    = '0;
                    n_state = ST_STAT_RD;
                end else begin
                    n_rd    = r_rd + 1'b1;
                    n_state = ST_SRCH_RD;
                end
            end
            ST_PRN_RD: begin
                if (r_rd == r_count) begin
                    n_count = r_wr;
                    n_rd    = '0;
                    n_state = ST_STAT_RD;
                end else begin
                    n_state = ST_PRN_CHK;
                end
            end
            ST_PRN_CHK: begin
                // keep survivors in order, compacting down to r_wr
                if (age <= r_max_age) begin
                    mem_we = 1'b1;
                    n_wr   = r_wr + 1'b1;
                end else begin
                    n_removed = r_removed + 1'b1;
                end
                n_rd    = r_rd + 1'b1;
                n_state = ST_PRN_RD;
            end
            ST_STAT_RD: begin
                if (r_rd == r_count) begin
                    n_rem   = '0;
                    n_quo   = sum_mag;
                    n_dcnt  = '0;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_STAT_ACC;
                end
            end
            ST_STAT_ACC: begin
                if (r_rd_data[47:40] == 8'd1) n_direct = r_direct + 1'b1;
                n_sum   = r_sum + SUM_W'(signed'(r_rd_data[39:32]));
                n_rd    = r_rd + 1'b1;
                n_state = ST_STAT_RD;
            end
            ST_DIV: begin
                // one quotient bit a cycle; r_quo shifts out dividend bits
                if (r_count == '0) begin
                    n_quo   = '0;
                    n_state = ST_FLAGS;
                end else begin
                    logic [CNT_W:0] rs;
                    rs = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
                    if (rs >= {1'b0, r_count}) begin
                        n_rem = rs - {1'b0, r_count};
                        n_quo = {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        n_rem = rs;
                        n_quo = {r_quo[SUM_W-2:0], 1'b0};
                    end
                    n_dcnt = r_dcnt + 1'b1;
                    if (r_dcnt == DCNT_W'(SUM_W - 1)) n_state = ST_FLAGS;
                end
            end
            ST_FLAGS: begin
                n_avg  = signed'(quo_s[7:0]);
                n_edge = (8'(r_direct) < r_edge_lim) || (signed'(quo_s[7:0]) < r_thr);
                n_cand = (8'(r_direct) >= r_cand_lim)
                      && (r_count != CNT_W'(TABLE_DEPTH))
                      && !(signed'(quo_s[7:0]) < r_thr);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {5'd0, r_cand, r_edge, r_avg, 8'(r_direct),
                            8'(r_count), 8'(r_removed), r_acc};

endmodule

@@ design/mnt_checker.sv @@
// ============================================================================
// mnt_checker: port-level checks of the mesh neighbor table
// Watches the stream handshakes and the result fields over time.
// ============================================================================
module mnt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // never ready for input while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    // an accepted input is not answered in the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("early result");
    // direct count never exceeds entry count
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[24:17] <= m_axis_tdata[16:9]))
        else $error("direct above total");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");
endmodule

bind mesh_neighbor_table mnt_checker u_mnt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
